FILE: hdl/mcc_pkg.sv
// Package for the minimum coin change block: widths, marks and register codes.
// No dependencies; imported by the interfaces and by min_coin_change_dp.

package mcc_pkg;

    localparam int COIN_W    = 10;               // coin value, target and count width
    localparam int CNT_W     = 11;               // table entry width
    localparam int REG_COUNT = 4;                // coin registers
    localparam int CFG_IDX_W = $clog2(REG_COUNT);

    typedef logic [COIN_W-1:0]    t_coin;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // all-ones entry marks a sum that cannot be formed
    localparam t_cnt NONE_MARK = {CNT_W{1'b1}};

    localparam t_cfg_idx CFG_COIN_A = 2'd0;
    localparam t_cfg_idx CFG_COIN_B = 2'd1;
    localparam t_cfg_idx CFG_COIN_C = 2'd2;
    localparam t_cfg_idx CFG_COIN_D = 2'd3;

    localparam t_coin COIN_A_RST = 10'd1;
    localparam t_coin COIN_B_RST = 10'd3;
    localparam t_coin COIN_C_RST = 10'd4;
    localparam t_coin COIN_D_RST = 10'd0;

endpackage

FILE: hdl/mcc_req_if.sv
// Request channel of the minimum coin change block: valid/ready plus target.
// Depends on mcc_pkg.

interface mcc_req_if
    import mcc_pkg::*;
();
    logic  valid;
    logic  ready;
    t_coin target;

    modport source (output valid, output target, input ready);
    modport sink   (input valid, input target, output ready);
endinterface

FILE: hdl/mcc_rsp_if.sv
// Response channel of the minimum coin change block: valid/ready plus result.
// Depends on mcc_pkg.

interface mcc_rsp_if
    import mcc_pkg::*;
();
    logic  valid;
    logic  ready;
    t_coin min_coins;
    logic  reachable;

    modport source (output valid, output min_coins, output reachable, input ready);
    modport sink   (input valid, input min_coins, input reachable, output ready);
endinterface

FILE: hdl/mcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module mcc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/min_coin_change_dp.sv
// Minimum coin change: top level with coin registers, table sequencer and result register.
// Depends on mcc_pkg, mcc_req_if, mcc_rsp_if and mcc_ram.

// A request carries a target sum; the response gives the fewest coins, taken with
// repetition from the configured coin values (0 = unused slot), that add up to it, or
// reachable=0 with a count of 0. The block fills a table in one RAM from sum 0 up to the
// target; for every sum it steps through the coin slots (one RAM read per nonzero coin
// no larger than the sum), then writes the new entry. Targets of 0 or above MAX_SUM skip
// the table. One request is in work at a time; the result sits in an output register
// and the next request is accepted while it waits. Coin registers are to be written only
// while idle; the block itself does not enforce this.

module min_coin_change_dp
    import mcc_pkg::*;
#(
    parameter int MAX_SUM   = 1023,
    parameter int NUM_COINS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_coin    i_cfg_data,
    mcc_req_if.sink  i_req,
    mcc_rsp_if.source o_rsp
);
    localparam int AW = $clog2(MAX_SUM + 1);
    localparam int SW = (AW > COIN_W) ? AW : COIN_W;
    localparam int KW = $clog2(NUM_COINS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state        r_state;
    t_coin         r_coin [REG_COUNT];
    logic [AW-1:0] r_goal;
    logic [AW-1:0] r_i;
    logic [KW-1:0] r_k;
    logic          r_pend;
    t_cnt          r_acc;
    t_cnt          r_best;
    logic          r_out_vld;
    t_coin         r_out_cnt;
    logic          r_out_reach;

    t_coin         coin_k;
    logic          use_k;
    logic          last_k;
    t_cnt          cand;
    t_cnt          rd_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_cnt          wr_data;
    logic          req_acc;
    logic          in_range;
    logic [SW-1:0] diff;

    assign req_acc  = i_req.valid && i_req.ready;
    assign in_range = SW'(i_req.target) <= SW'(MAX_SUM);
    assign last_k   = (r_k == KW'(NUM_COINS));

    // coin of the current slot; slots past the registers read as unused
    always_comb begin
        coin_k = '0;
        for (int j = 0; j < REG_COUNT; j++) begin
            if (int'(r_k) == j) begin
                coin_k = r_coin[j];
            end
        end
    end

    assign diff  = SW'(r_i) - SW'(coin_k);
    assign use_k = (r_state == ST_SCAN) && !last_k && (coin_k != '0)
                   && (SW'(coin_k) <= SW'(r_i));

    // fold in the entry read on the previous cycle
    always_comb begin
        cand = r_acc;
        if (r_pend && (rd_data != NONE_MARK) && ((rd_data + t_cnt'(1)) < r_acc)) begin
            cand = rd_data + t_cnt'(1);
        end
    end

    always_comb begin
        rd_en   = use_k;
        rd_addr = diff[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (r_state == ST_IDLE) begin
            wr_en = req_acc && in_range;   // entry 0 is always 0
        end else if (r_state == ST_SCAN && last_k) begin
            wr_en   = 1'b1;
            wr_addr = r_i;
            wr_data = cand;
        end
    end

    mcc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SUM + 1)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_coin[0]   <= COIN_A_RST;
            r_coin[1]   <= COIN_B_RST;
            r_coin[2]   <= COIN_C_RST;
            r_coin[3]   <= COIN_D_RST;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COIN_A: r_coin[0] <= i_cfg_data;
                    CFG_COIN_B: r_coin[1] <= i_cfg_data;
                    CFG_COIN_C: r_coin[2] <= i_cfg_data;
                    CFG_COIN_D: r_coin[3] <= i_cfg_data;
                    default: ;
                endcase
            end

            // in ST_DONE the result register load below covers the handshake
            if (o_rsp.valid && o_rsp.ready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end

            r_pend <= use_k;

            case (r_state)
                ST_IDLE: begin
                    if (req_acc) begin
                        r_goal <= AW'(i_req.target);
                        r_i    <= AW'(1);
                        r_k    <= '0;
                        r_acc  <= NONE_MARK;
                        if (!in_range) begin
                            r_best  <= NONE_MARK;
                            r_state <= ST_DONE;
                        end else if (i_req.target == '0) begin
                            r_best  <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (last_k) begin
                        r_k   <= '0;
                        r_acc <= NONE_MARK;
                        if (r_i == r_goal) begin
                            r_best  <= cand;
                            r_state <= ST_DONE;
                        end else begin
                            r_i <= r_i + AW'(1);
                        end
                    end else begin
                        r_acc <= cand;
                        r_k   <= r_k + KW'(1);
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld   <= 1'b1;
                        r_out_reach <= (r_best != NONE_MARK);
                        r_out_cnt   <= (r_best != NONE_MARK) ? r_best[COIN_W-1:0] : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.min_coins = r_out_cnt;
    assign o_rsp.reachable = r_out_reach;
endmodule

FILE: hdl/mcc_chk.sv
// Port-level checker for the minimum coin change block, bound to the top level.
// Depends on min_coin_change_dp's ports only.

module mcc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_min_coins,
    input logic       i_reachable
);
    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_min_coins)
        && $stable(i_reachable))
        else $error("result changed while stalled");

    // an unreachable sum reports a zero count
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_reachable |-> i_min_coins == 10'd0)
        else $error("unreachable result with nonzero count");

    // one request in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");
endmodule

bind min_coin_change_dp mcc_chk u_mcc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_min_coins (o_rsp.min_coins),
    .i_reachable (o_rsp.reachable)
);
